/* src/eptt_pkg.sv */
`default_nettype none

package eptt_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_COORD_BITS    = 12;
  localparam int DEF_FRAC_BITS     = 4;

  // Fixed field widths.
  localparam int CENTER_W    = 12;
  localparam int RADIUS_W    = 8;
  localparam int OUT_W       = 18;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_X = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_Y = 3'd3;

  // Reset values of the registers.
  localparam logic [CENTER_W-1:0] RST_CENTER_X = 12'd305;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y = 12'd300;
  localparam logic [RADIUS_W-1:0] RST_RADIUS_X = 8'd50;
  localparam logic [RADIUS_W-1:0] RST_RADIUS_Y = 8'd30;

  // Rotation datapath: cos and sin in Q2.30.
  localparam int CS_W      = 32;
  localparam int CS_FRAC   = 30;
  localparam int PRE_SHIFT = 8;
  localparam logic signed [CS_W-1:0] KINV_Q30 = 32'sd652032874;
  localparam logic signed [CS_W-1:0] ONE_Q30  = 32'sd1073741824;

endpackage

`default_nettype wire

/* src/eptt_target_if.sv */
`default_nettype none

interface eptt_target_if
  import eptt_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] target_x;
  logic [COORD_BITS-1:0] target_y;

  modport source (output valid, output target_x, output target_y, input ready);
  modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

`default_nettype wire

/* src/eptt_point_if.sv */
`default_nettype none

interface eptt_point_if
  import eptt_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] point_x;
  logic signed [OUT_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

/* src/eptt_cfg_if.sv */
`default_nettype none

interface eptt_cfg_if
  import eptt_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/ellipse_point_toward_target.sv */
// Channel   Direction  Word
// --------  ---------  ------------------------------------------------
// target    in         target_x, target_y (whole pixels)
// point     out        point_x, point_y (signed, 1/16 pixel)
// cfg       in         index, data (register write, always ready)
//
// One word enters per cycle unless the output is stalled and every stage is full;
// each result passes the registered stages of the stage map, with a fused vectoring/rotation CORDIC.
// Every stage has its own valid bit and advances when the stage after it is
// empty or advancing, so bubbles close up while the output is stalled.
// rst is synchronous and clears the valid bits and loads the register
// defaults; the datapath registers are not reset.
`default_nettype none

module ellipse_point_toward_target
  import eptt_pkg::*;
#(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int COORD_BITS    = DEF_COORD_BITS,
  parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  eptt_target_if.sink   target,
  eptt_point_if.source  point,
  eptt_cfg_if.sink      cfg
);

  localparam int DW  = COORD_BITS + 1;               // offset from the centre
  localparam int PW  = DW + RADIUS_W + 1;            // offset times radius
  localparam int VW  = PW + PRE_SHIFT + 2;           // vectoring, with CORDIC growth
  localparam int MW  = CS_W + RADIUS_W + 1;          // radius times cos or sin
  localparam int RS  = CS_FRAC - FRAC_BITS;          // rounding shift
  localparam int QW  = MW - RS;                      // rounded magnitude
  localparam int NST = CORDIC_STAGES + 7;            // register stages in total
  localparam logic [MW-1:0] HALF = MW'(1) << (RS - 1);

  // Stage map: 0 offset, 1 products, 2 fold, 3..CORDIC_STAGES+2 CORDIC,
  // then cos/sin select, radius multiply, rounding, output register.
  localparam int ST_CSEL = CORDIC_STAGES + 3;
  localparam int ST_MUL  = CORDIC_STAGES + 4;
  localparam int ST_RND  = CORDIC_STAGES + 5;
  localparam int ST_OUT  = CORDIC_STAGES + 6;

  // Configuration registers.
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;
  logic [RADIUS_W-1:0] radius_x;
  logic [RADIUS_W-1:0] radius_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= RST_CENTER_X;
      center_y <= RST_CENTER_Y;
      radius_x <= RST_RADIUS_X;
      radius_y <= RST_RADIUS_Y;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CENTER_X: center_x <= cfg.data[CENTER_W-1:0];
        REG_CENTER_Y: center_y <= cfg.data[CENTER_W-1:0];
        REG_RADIUS_X: radius_x <= cfg.data[RADIUS_W-1:0];
        REG_RADIUS_Y: radius_y <= cfg.data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // The user must change the registers only while the pipeline is empty; the block
  // does not enforce this. Given that, every stage may read them directly.
  logic [COORD_BITS-1:0]      cx;
  logic [COORD_BITS-1:0]      cy;
  logic signed [RADIUS_W:0]   rx_s;
  logic signed [RADIUS_W:0]   ry_s;

  assign cx   = COORD_BITS'(center_x);
  assign cy   = COORD_BITS'(center_y);
  assign rx_s = $signed({1'b0, radius_x});
  assign ry_s = $signed({1'b0, radius_y});

  // Flow control.
  logic [NST-1:0] vld;
  logic [NST-1:0] stage_en;

  always_comb begin
    stage_en[NST-1] = !vld[NST-1] || point.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      stage_en[k] = !vld[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (stage_en[0]) begin
        vld[0] <= target.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (stage_en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign target.ready = stage_en[0];

  // Stage 0: offset from the centre.
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dx <= $signed({1'b0, target.target_x}) - $signed({1'b0, cx});
      dy <= $signed({1'b0, target.target_y}) - $signed({1'b0, cy});
    end
  end

  // Stage 1: scale into ellipse space, (dx*ry, dy*rx).
  logic signed [PW-1:0] sx;
  logic signed [PW-1:0] sy;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      sx <= dx * ry_s;
      sy <= dy * rx_s;
    end
  end

  // Stage 2: fold the left half-plane onto the right and pre-shift.
  logic signed [VW-1:0] vx_r   [0:CORDIC_STAGES];
  logic signed [VW-1:0] vy_r   [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] c_r  [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] s_r  [0:CORDIC_STAGES];
  logic                 flip_r [0:CORDIC_STAGES];
  logic                 zero_r [0:CORDIC_STAGES];

  logic                 fold_flip;
  logic signed [PW-1:0] fold_x;
  logic signed [PW-1:0] fold_y;

  assign fold_flip = sx[PW-1];
  assign fold_x    = fold_flip ? -sx : sx;
  assign fold_y    = fold_flip ? -sy : sy;

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      vx_r[0]   <= VW'(fold_x) <<< PRE_SHIFT;
      vy_r[0]   <= VW'(fold_y) <<< PRE_SHIFT;
      c_r[0]    <= KINV_Q30;
      s_r[0]    <= '0;
      flip_r[0] <= fold_flip;
      zero_r[0] <= (sx == '0) && (sy == '0);
    end
  end

  // CORDIC: each stage takes one vectoring step and applies the same
  // direction, in the opposite sense, to the rotating (cos, sin) pair.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic cw;

    assign cw = !vy_r[i][VW-1] && (vy_r[i] != '0);

    always_ff @(posedge clk) begin
      if (stage_en[3+i]) begin
        if (cw) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          c_r[i+1]  <= c_r[i] - (s_r[i] >>> i);
          s_r[i+1]  <= s_r[i] + (c_r[i] >>> i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          c_r[i+1]  <= c_r[i] + (s_r[i] >>> i);
          s_r[i+1]  <= s_r[i] - (c_r[i] >>> i);
        end
        flip_r[i+1] <= flip_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // Select cos and sin: angle zero for a zero offset, plus pi when folded.
  logic signed [CS_W-1:0] cos_q;
  logic signed [CS_W-1:0] sin_q;

  always_ff @(posedge clk) begin
    if (stage_en[ST_CSEL]) begin
      priority if (zero_r[CORDIC_STAGES]) begin
        cos_q <= ONE_Q30;
        sin_q <= '0;
      end else if (flip_r[CORDIC_STAGES]) begin
        cos_q <= -c_r[CORDIC_STAGES];
        sin_q <= -s_r[CORDIC_STAGES];
      end else begin
        cos_q <= c_r[CORDIC_STAGES];
        sin_q <= s_r[CORDIC_STAGES];
      end
    end
  end

  // Scale by the semi-axes.
  logic signed [MW-1:0] mx;
  logic signed [MW-1:0] my;

  always_ff @(posedge clk) begin
    if (stage_en[ST_MUL]) begin
      mx <= cos_q * rx_s;
      my <= sin_q * ry_s;
    end
  end

  // Round half away from zero on the magnitude.
  logic [MW-1:0] mag_x;
  logic [MW-1:0] mag_y;
  logic [MW-1:0] sum_x;
  logic [MW-1:0] sum_y;
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;
  logic          neg_x;
  logic          neg_y;

  assign mag_x = mx[MW-1] ? $unsigned(-mx) : $unsigned(mx);
  assign mag_y = my[MW-1] ? $unsigned(-my) : $unsigned(my);
  assign sum_x = mag_x + HALF;
  assign sum_y = mag_y + HALF;

  always_ff @(posedge clk) begin
    if (stage_en[ST_RND]) begin
      qx    <= sum_x[MW-1:RS];
      qy    <= sum_y[MW-1:RS];
      neg_x <= mx[MW-1];
      neg_y <= my[MW-1];
    end
  end

  // Restore the sign and add the centre in sixteenths; the sum wraps.
  logic signed [QW:0]      rx_off;
  logic signed [QW:0]      ry_off;
  logic signed [OUT_W-1:0] rx_ext;
  logic signed [OUT_W-1:0] ry_ext;
  logic [OUT_W-1:0]        cx_frac;
  logic [OUT_W-1:0]        cy_frac;
  logic signed [OUT_W-1:0] px;
  logic signed [OUT_W-1:0] py;

  assign rx_off  = neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign ry_off  = neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
  assign rx_ext  = OUT_W'(rx_off);
  assign ry_ext  = OUT_W'(ry_off);
  assign cx_frac = OUT_W'(cx) << FRAC_BITS;
  assign cy_frac = OUT_W'(cy) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (stage_en[ST_OUT]) begin
      px <= $signed(cx_frac + $unsigned(rx_ext));
      py <= $signed(cy_frac + $unsigned(ry_ext));
    end
  end

  assign point.valid   = vld[ST_OUT];
  assign point.point_x = px;
  assign point.point_y = py;

`ifndef SYNTHESIS
  // Input is refused only when every stage holds a word.
  a_refuse_only_full: assert property (@(posedge clk) disable iff (rst)
    !target.ready |-> (&vld))
    else $error("input refused while the pipeline has a free stage");

  // After folding, the vector starts in the right half-plane.
  a_fold_right: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && !zero_r[0]) |-> !vx_r[0][VW-1])
    else $error("folded vector has negative x");

  // The vectoring x never wraps through the CORDIC growth.
  a_cordic_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_CSEL-1] && !zero_r[CORDIC_STAGES]) |-> !vx_r[CORDIC_STAGES][VW-1])
    else $error("vectoring x overflowed");

  // A stalled output register keeps its word.
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (point.valid && !point.ready) |=> (point.valid && $stable(px) && $stable(py)))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* verif/ellipse_point_toward_target_tb.sv */
`timescale 1ns / 100ps

module ellipse_point_toward_target_tb;
  import eptt_pkg::*;

  localparam int STAGES         = DEF_CORDIC_STAGES;
  localparam int COORD_W        = DEF_COORD_BITS;
  localparam int FRAC           = DEF_FRAC_BITS;
  localparam int LATENCY        = STAGES + 7;
  localparam int CLK_PERIOD     = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 7;
  localparam int PHASE_ITEMS    = 200;
  localparam int MAX_REPORTS    = 10;

  // Indexes past the last register; the block drops writes to them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {ROW_ITEM, ROW_KNOWN, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
  } point_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic [COORD_W-1:0]     tx;
    logic [COORD_W-1:0]     ty;
    logic [OUT_W-1:0]       px;
    logic [OUT_W-1:0]       py;
  } stim_row_t;

  localparam int N_DIRECTED = 33;

  // Fixed points are typed in only where the scaled offset is zero, so the angle is zero.
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_KNOWN, REG_CENTER_X, '0, 12'd305, 12'd300, 18'd5680, 18'd4800},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd0, 12'd0, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd4095, 12'd4095, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd0, 12'd4095, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd4095, 12'd0, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd0, 12'd300, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd305, 12'd0, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd305, 12'd4095, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd306, 12'd301, '0, '0},
    '{ROW_CFG,   REG_SPARE_LAST, 12'hFFF, '0, '0, '0, '0},
    '{ROW_KNOWN, REG_CENTER_X, '0, 12'd305, 12'd300, 18'd5680, 18'd4800},
    '{ROW_CFG,   REG_RADIUS_X, 12'h100, '0, '0, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd1000, 12'd300, '0, '0},
    '{ROW_KNOWN, REG_CENTER_X, '0, 12'd305, 12'd1000, 18'd4880, 18'd4800},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd200, 12'd50, '0, '0},
    '{ROW_CFG,   REG_CENTER_X, 12'd0, '0, '0, '0, '0},
    '{ROW_CFG,   REG_CENTER_Y, 12'd0, '0, '0, '0, '0},
    '{ROW_CFG,   REG_RADIUS_X, 12'd255, '0, '0, '0, '0},
    '{ROW_CFG,   REG_RADIUS_Y, 12'hFFF, '0, '0, '0, '0},
    '{ROW_KNOWN, REG_CENTER_X, '0, 12'd0, 12'd0, 18'd4080, 18'd0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd4095, 12'd4095, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd4095, 12'd0, '0, '0},
    '{ROW_CFG,   REG_CENTER_X, 12'd4095, '0, '0, '0, '0},
    '{ROW_CFG,   REG_CENTER_Y, 12'd4095, '0, '0, '0, '0},
    '{ROW_CFG,   REG_RADIUS_X, 12'd1, '0, '0, '0, '0},
    '{ROW_CFG,   REG_RADIUS_Y, 12'd1, '0, '0, '0, '0},
    '{ROW_KNOWN, REG_CENTER_X, '0, 12'd4095, 12'd4095, 18'd65536, 18'd65520},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd0, 12'd0, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd0, 12'd4095, '0, '0},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd4095, 12'd0, '0, '0},
    '{ROW_CFG,   REG_RADIUS_Y, 12'd0, '0, '0, '0, '0},
    '{ROW_KNOWN, REG_CENTER_X, '0, 12'd0, 12'd4095, 18'd65536, 18'd65520},
    '{ROW_ITEM,  REG_CENTER_X, '0, 12'd4095, 12'd0, '0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  always #(CLK_PERIOD / 2) clk = ~clk;

  eptt_target_if #(.COORD_BITS(COORD_W)) target_ch ();
  eptt_point_if                          point_ch ();
  eptt_cfg_if                            cfg_ch ();

  ellipse_point_toward_target #(
    .CORDIC_STAGES(STAGES),
    .COORD_BITS   (COORD_W),
    .FRAC_BITS    (FRAC)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .target(target_ch),
    .point (point_ch),
    .cfg   (cfg_ch)
  );

  logic [CENTER_W-1:0] cur_cx = RST_CENTER_X;
  logic [CENTER_W-1:0] cur_cy = RST_CENTER_Y;
  logic [RADIUS_W-1:0] cur_rx = RST_RADIUS_X;
  logic [RADIUS_W-1:0] cur_ry = RST_RADIUS_Y;

  point_t pending_points[$];
  int     mismatches = 0;
  bit     rx_steady  = 1'b0;

  function automatic longint round_away(input longint v, input int sh);
    longint half;
    half = longint'(1) <<< (sh - 1);
    if (v >= 0) return (v + half) >>> sh;
    return -((-v + half) >>> sh);
  endfunction

  // The vectoring pass only records rotation directions; the rotation pass
  // replays them on the inverse gain to get cos and sin in Q2.30.
  function automatic point_t project_onto_ellipse(input logic [COORD_W-1:0] tx,
                                                  input logic [COORD_W-1:0] ty);
    longint dx, dy, vx, vy, c, s, step_x, step_y, ox, oy;
    bit     turn_cw [STAGES];
    bit     flipped;
    point_t pt;
    dx = longint'(tx) - longint'(cur_cx);
    dy = longint'(ty) - longint'(cur_cy);
    vx = dx * longint'(cur_ry);
    vy = dy * longint'(cur_rx);
    flipped = 1'b0;
    if (vx == 0 && vy == 0) begin
      c = longint'(ONE_Q30);
      s = 0;
    end else begin
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        flipped = 1'b1;
      end
      vx = vx <<< PRE_SHIFT;
      vy = vy <<< PRE_SHIFT;
      for (int i = 0; i < STAGES; i++) begin
        step_x = vx >>> i;
        step_y = vy >>> i;
        turn_cw[i] = (vy > 0);
        if (turn_cw[i]) begin
          vx = vx + step_y;
          vy = vy - step_x;
        end else begin
          vx = vx - step_y;
          vy = vy + step_x;
        end
      end
      c = longint'(KINV_Q30);
      s = 0;
      for (int i = 0; i < STAGES; i++) begin
        step_x = c >>> i;
        step_y = s >>> i;
        if (turn_cw[i]) begin
          c = c - step_y;
          s = s + step_x;
        end else begin
          c = c + step_y;
          s = s - step_x;
        end
      end
      if (flipped) begin
        c = -c;
        s = -s;
      end
    end
    ox = (longint'(cur_cx) <<< FRAC) + round_away(longint'(cur_rx) * c, CS_FRAC - FRAC);
    oy = (longint'(cur_cy) <<< FRAC) + round_away(longint'(cur_ry) * s, CS_FRAC - FRAC);
    pt.x = ox[OUT_W-1:0];
    pt.y = oy[OUT_W-1:0];
    return pt;
  endfunction

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [CENTER_W-1:0] pick_center();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return CENTER_W'($urandom());
  endfunction

  // Radius in the low bits; the upper bits of the word are noise to be dropped.
  function automatic logic [CFG_DATA_W-1:0] pick_radius_word();
    int                  r;
    logic [RADIUS_W-1:0] rad;
    r = $urandom_range(0, 99);
    if (r < 10) rad = '0;
    else if (r < 25) rad = RADIUS_W'(1);
    else if (r < 45) rad = '1;
    else rad = RADIUS_W'($urandom_range(1, 255));
    return {(CFG_DATA_W - RADIUS_W)'($urandom()), rad};
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] centre);
    int v;
    v = $urandom_range(0, 16);
    v = v - 8 + int'(centre);
    if (v < 0) v = 0;
    if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return COORD_W'(v);
  endfunction

  task automatic pick_target(output logic [COORD_W-1:0] tx, output logic [COORD_W-1:0] ty);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      tx = COORD_W'($urandom());
      ty = COORD_W'($urandom());
    end else if (r < 75) begin
      tx = near_coord(cur_cx);
      ty = near_coord(cur_cy);
    end else if (r < 83) begin
      tx = cur_cx;
      ty = cur_cy;
    end else if (r < 93) begin
      tx = $urandom_range(0, 1) ? cur_cx : COORD_W'($urandom());
      ty = (tx == cur_cx) ? COORD_W'($urandom()) : cur_cy;
    end else begin
      tx = $urandom_range(0, 1) ? '1 : '0;
      ty = $urandom_range(0, 1) ? '1 : '0;
    end
  endtask

  // Leaves valid high when the next word follows without a gap.
  task automatic send_target(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty,
                             input bit typed, input point_t typed_pt, input int gap);
    target_ch.valid    <= 1'b1;
    target_ch.target_x <= tx;
    target_ch.target_y <= ty;
    do @(posedge clk); while (!target_ch.ready);
    pending_points.push_back(typed ? typed_pt : project_onto_ellipse(tx, ty));
    if (gap > 0) begin
      target_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    target_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      REG_CENTER_X: cur_cx = data;
      REG_CENTER_Y: cur_cy = data;
      REG_RADIUS_X: cur_rx = data[RADIUS_W-1:0];
      REG_RADIUS_Y: cur_ry = data[RADIUS_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side back-pressure.
  initial begin
    int rx_hold;
    rx_hold = 0;
    point_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
      end else if (rx_steady) begin
        point_ch.ready <= 1'b1;
      end else if (point_ch.ready) begin
        point_ch.ready <= 1'b0;
        rx_hold = idle_len();
      end else begin
        point_ch.ready <= 1'b1;
        rx_hold = $urandom_range(0, 15);
      end
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && point_ch.valid && point_ch.ready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected point (%0d, %0d) with nothing pending",
                   $signed(point_ch.point_x), $signed(point_ch.point_y));
      end else begin
        want = pending_points.pop_front();
        if (point_ch.point_x !== want.x || point_ch.point_y !== want.y) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("point mismatch: point_x exp %0d got %0d, point_y exp %0d got %0d",
                     $signed(want.x), $signed(point_ch.point_x),
                     $signed(want.y), $signed(point_ch.point_y));
        end
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((target_ch.valid && target_ch.ready) || (point_ch.valid && point_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    stim_row_t          row;
    logic [COORD_W-1:0] tx, ty;
    bit                 quiet;
    rst                = 1'b1;
    target_ch.valid    = 1'b0;
    target_ch.target_x = '0;
    target_ch.target_y = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_CENTER_X;
    cfg_ch.data        = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        wait_for_drain();
        write_reg(row.index, row.data);
      end else begin
        send_target(row.tx, row.ty, row.kind == ROW_KNOWN, {row.px, row.py}, idle_len());
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_drain();
      write_reg(REG_CENTER_X, pick_center());
      write_reg(REG_CENTER_Y, pick_center());
      write_reg(REG_RADIUS_X, pick_radius_word());
      write_reg(REG_RADIUS_Y, pick_radius_word());
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom()));
      // One phase runs with neither side idling.
      quiet = (p == NUM_PHASES - 2);
      rx_steady <= quiet;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((p == 0 && n == PHASE_ITEMS / 2) || $urandom_range(0, 249) == 0)
          wait_for_drain();
        pick_target(tx, ty);
        send_target(tx, ty, 1'b0, '0, quiet ? 0 : idle_len());
      end
    end

    wait_for_drain();
    rx_steady <= 1'b1;
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_points.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
